// File: design/btpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants for the barometric temperature and pressure
// compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

  // field widths
  localparam int RAW_W   = 20;
  localparam int TC_W    = 16;
  localparam int PRESS_W = 32;
  localparam int CFG_W   = 64;

  // divider geometry: magnitude of numerator, divisor and quotient bits
  localparam int NABS_W  = 62;
  localparam int NUM_W   = 74;
  localparam int DEN_W   = 36;
  localparam int DIV_W   = 36;
  localparam int P_W     = DIV_W + 1;
  localparam int DENS_W  = 40;

  // compensation constants
  localparam int T_OFFSET   = 128000;
  localparam int PRESS_BASE = 1048576;
  localparam logic [DIV_W-1:0] Q_SAT = DIV_W'(64'd1 << 35);
  localparam logic signed [TC_W-1:0] TC_MAX = 16'sh7fff;
  localparam logic signed [TC_W-1:0] TC_MIN = 16'sh8000;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEMP      = 2'd0,
    CFG_PRESS_LOW = 2'd1,
    CFG_PRESS_HI  = 2'd2,
    CFG_PRESS_P9  = 2'd3
  } btpc_cfg_idx_t;

  // sideband that travels with a beat through the divider
  typedef struct packed {
    logic                   vld;
    logic                   inv;
    logic signed [TC_W-1:0] tc;
  } btpc_tag_t;

endpackage

// File: design/baro_temp_pressure_compensate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensate
// Integer compensation of raw barometric sensor readings into temperature
// (0.01 degC) and pressure (Pa, Q24.8) from twelve calibration coefficients.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  input     in_raw_temperature, in_raw_pressure     start && !busy
//  result    out_temperature_centi, out_pressure_q24_8,
//            out_pressure_invalid                    out_valid strobe
//  config    cfg_index, cfg_data                     cfg_we
//
//  One beat enters every cycle; busy is always low. A result passes through
//  9 front stages, 39 in the divider (one quotient bit per restoring step)
//  and 4 correction stages. Synchronous active-low reset clears all valid
//  bits and the coefficient registers. There is no stall: each result is
//  shown for one cycle with out_valid.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensate
  import btpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [RAW_W-1:0]         in_raw_temperature,
  input  logic [RAW_W-1:0]         in_raw_pressure,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output logic                     out_valid,
  output logic signed [TC_W-1:0]   out_temperature_centi,
  output logic [PRESS_W-1:0]       out_pressure_q24_8,
  output logic                     out_pressure_invalid
);

  // coefficient registers
  logic [47:0] temp_coeffs_r;
  logic [63:0] press_lo_r;
  logic [63:0] press_hi_r;
  logic [15:0] p9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_lo_r    <= '0;
      press_hi_r    <= '0;
      p9_r          <= '0;
    end else if (cfg_we) begin
      case (btpc_cfg_idx_t'(cfg_index))
        CFG_TEMP:      temp_coeffs_r <= cfg_data[47:0];
        CFG_PRESS_LOW: press_lo_r    <= cfg_data;
        CFG_PRESS_HI:  press_hi_r    <= cfg_data;
        CFG_PRESS_P9:  p9_r          <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // coefficient fields
  logic [15:0]        t1, p1;
  logic signed [16:0] p1s;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  always_comb begin
    t1  = temp_coeffs_r[15:0];
    t2  = $signed(temp_coeffs_r[31:16]);
    t3  = $signed(temp_coeffs_r[47:32]);
    p1  = press_lo_r[15:0];
    p1s = $signed({1'b0, p1});
    p2  = $signed(press_lo_r[31:16]);
    p3  = $signed(press_lo_r[47:32]);
    p4  = $signed(press_lo_r[63:48]);
    p5  = $signed(press_hi_r[15:0]);
    p6  = $signed(press_hi_r[31:16]);
    p7  = $signed(press_hi_r[47:32]);
    p8  = $signed(press_hi_r[63:48]);
    p9  = $signed(p9_r);
  end

  assign busy = 1'b0;

  // stage 1: temperature products
  logic                    in_fire;
  logic signed [18:0]      diff1;
  logic signed [17:0]      dt;
  logic signed [35:0]      dd_full;
  logic signed [34:0]      s1_x1_nxt, s1_x1_r;
  logic [31:0]             s1_dd_r;
  logic [RAW_W-1:0]        s1_adcp_r;
  logic                    s1_vld_r;

  always_comb begin
    in_fire   = start && !busy;
    diff1     = $signed({2'b00, in_raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
    dt        = $signed({2'b00, in_raw_temperature[19:4]}) - $signed({2'b00, t1});
    s1_x1_nxt = 35'(diff1) * 35'(t2);
    dd_full   = 36'(dt) * 36'(dt);
  end

  // stage 2: v1 and the t3 product
  logic signed [23:0] s2_v1_nxt, s2_v1_r;
  logic signed [36:0] s2_m2_nxt, s2_m2_r;
  logic [RAW_W-1:0]   s2_adcp_r;
  logic               s2_vld_r;

  always_comb begin
    s2_v1_nxt = 24'(s1_x1_r >>> 11);
    s2_m2_nxt = 37'($signed({1'b0, s1_dd_r[31:12]})) * 37'(t3);
  end

  // stage 3: fine temperature
  logic signed [24:0] s3_tfine_nxt, s3_tfine_r;
  logic [RAW_W-1:0]   s3_adcp_r;
  logic               s3_vld_r;

  assign s3_tfine_nxt = 25'(s2_v1_r) + 25'(s2_m2_r >>> 14);

  // stage 4: offset temperature square and linear terms, centidegrees
  logic signed [25:0]     a_t;
  logic signed [47:0]     aa_full;
  logic signed [27:0]     t5;
  logic signed [19:0]     tcw;
  logic [45:0]            s4_aa_r;
  logic signed [41:0]     s4_ap5_nxt, s4_ap5_r, s4_ap2_nxt, s4_ap2_r;
  logic signed [TC_W-1:0] s4_tc_nxt, s4_tc_r;
  logic [RAW_W-1:0]       s4_adcp_r;
  logic                   s4_vld_r;

  always_comb begin
    a_t        = 26'(s3_tfine_r) - 26'(T_OFFSET);
    aa_full    = 48'(a_t) * 48'(a_t);
    s4_ap5_nxt = 42'(a_t) * 42'(p5);
    s4_ap2_nxt = 42'(a_t) * 42'(p2);
    t5         = 28'(s3_tfine_r) * 28'sd5 + 28'sd128;
    tcw        = 20'(t5 >>> 8);
    if (tcw > 20'(TC_MAX)) begin
      s4_tc_nxt = TC_MAX;
    end else if (tcw < 20'(TC_MIN)) begin
      s4_tc_nxt = TC_MIN;
    end else begin
      s4_tc_nxt = 16'(tcw);
    end
  end

  // stage 5: split square times p6 and p3
  logic signed [39:0]     s5_h6_nxt, s5_h6_r, s5_l6_nxt, s5_l6_r;
  logic signed [39:0]     s5_h3_nxt, s5_h3_r, s5_l3_nxt, s5_l3_r;
  logic signed [41:0]     s5_ap5_r, s5_ap2_r;
  logic signed [TC_W-1:0] s5_tc_r;
  logic [RAW_W-1:0]       s5_adcp_r;
  logic                   s5_vld_r;

  always_comb begin
    s5_h6_nxt = 40'($signed({1'b0, s4_aa_r[45:23]})) * 40'(p6);
    s5_l6_nxt = 40'($signed({1'b0, s4_aa_r[22:0]})) * 40'(p6);
    s5_h3_nxt = 40'($signed({1'b0, s4_aa_r[45:23]})) * 40'(p3);
    s5_l3_nxt = 40'($signed({1'b0, s4_aa_r[22:0]})) * 40'(p3);
  end

  // stage 6: join partial products
  logic signed [63:0]     s6_aap6_nxt, s6_aap6_r, s6_aap3_nxt, s6_aap3_r;
  logic signed [41:0]     s6_ap5_r, s6_ap2_r;
  logic signed [TC_W-1:0] s6_tc_r;
  logic [RAW_W-1:0]       s6_adcp_r;
  logic                   s6_vld_r;

  always_comb begin
    s6_aap6_nxt = (64'(s5_h6_r) <<< 23) + 64'(s5_l6_r);
    s6_aap3_nxt = (64'(s5_h3_r) <<< 23) + 64'(s5_l3_r);
  end

  // stage 7: numerator offset w2 and divisor base b
  logic signed [63:0]     s7_w2_nxt, s7_w2_r, s7_b_nxt, s7_b_r;
  logic signed [TC_W-1:0] s7_tc_r;
  logic [RAW_W-1:0]       s7_adcp_r;
  logic                   s7_vld_r;

  always_comb begin
    s7_w2_nxt = s6_aap6_r + (64'(s6_ap5_r) <<< 17) + (64'(p4) <<< 35);
    s7_b_nxt  = (64'sd1 <<< 47) + (s6_aap3_r >>> 8) + (64'(s6_ap2_r) <<< 12);
  end

  // stage 8: numerator, split b times p1
  logic signed [63:0]     s8_n_nxt, s8_n_r;
  logic signed [44:0]     s8_bhp_nxt, s8_bhp_r, s8_blp_nxt, s8_blp_r;
  logic signed [TC_W-1:0] s8_tc_r;
  logic                   s8_vld_r;

  always_comb begin
    s8_n_nxt   = ((64'(PRESS_BASE) - 64'($signed({1'b0, s7_adcp_r}))) <<< 31) - s7_w2_r;
    s8_bhp_nxt = 45'($signed(s7_b_r[54:27])) * 45'(p1s);
    s8_blp_nxt = 45'($signed({1'b0, s7_b_r[26:0]})) * 45'(p1s);
  end

  // stage 9: divisor and numerator magnitude
  logic signed [71:0]       bp;
  logic signed [63:0]       nmag;
  logic signed [DENS_W-1:0] s9_den_nxt, s9_den_r;
  logic [NABS_W-1:0]        s9_nabs_r;
  logic                     s9_nneg_r;
  logic signed [TC_W-1:0]   s9_tc_r;
  logic                     s9_vld_r;

  always_comb begin
    bp         = (72'(s8_bhp_r) <<< 27) + 72'(s8_blp_r);
    s9_den_nxt = DENS_W'(bp >>> 33);
    nmag       = s8_n_r[63] ? -s8_n_r : s8_n_r;
  end

  // front pipeline valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0;
      s9_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
      s8_vld_r <= s7_vld_r;
      s9_vld_r <= s8_vld_r;
    end
  end

  // front pipeline payload
  always_ff @(posedge clk) begin
    s1_x1_r      <= s1_x1_nxt;
    s1_dd_r      <= dd_full[31:0];
    s1_adcp_r    <= in_raw_pressure;
    s2_v1_r      <= s2_v1_nxt;
    s2_m2_r      <= s2_m2_nxt;
    s2_adcp_r    <= s1_adcp_r;
    s3_tfine_r   <= s3_tfine_nxt;
    s3_adcp_r    <= s2_adcp_r;
    s4_aa_r      <= aa_full[45:0];
    s4_ap5_r     <= s4_ap5_nxt;
    s4_ap2_r     <= s4_ap2_nxt;
    s4_tc_r      <= s4_tc_nxt;
    s4_adcp_r    <= s3_adcp_r;
    s5_h6_r      <= s5_h6_nxt;
    s5_l6_r      <= s5_l6_nxt;
    s5_h3_r      <= s5_h3_nxt;
    s5_l3_r      <= s5_l3_nxt;
    s5_ap5_r     <= s4_ap5_r;
    s5_ap2_r     <= s4_ap2_r;
    s5_tc_r      <= s4_tc_r;
    s5_adcp_r    <= s4_adcp_r;
    s6_aap6_r    <= s6_aap6_nxt;
    s6_aap3_r    <= s6_aap3_nxt;
    s6_ap5_r     <= s5_ap5_r;
    s6_ap2_r     <= s5_ap2_r;
    s6_tc_r      <= s5_tc_r;
    s6_adcp_r    <= s5_adcp_r;
    s7_w2_r      <= s7_w2_nxt;
    s7_b_r       <= s7_b_nxt;
    s7_tc_r      <= s6_tc_r;
    s7_adcp_r    <= s6_adcp_r;
    s8_n_r       <= s8_n_nxt;
    s8_bhp_r     <= s8_bhp_nxt;
    s8_blp_r     <= s8_blp_nxt;
    s8_tc_r      <= s7_tc_r;
    s9_den_r     <= s9_den_nxt;
    s9_nabs_r    <= nmag[NABS_W-1:0];
    s9_nneg_r    <= s8_n_r[63];
    s9_tc_r      <= s8_tc_r;
  end

  // pressure divide
  btpc_tag_t             div_in_tag, div_tag;
  logic signed [P_W-1:0] div_p;

  always_comb begin
    div_in_tag.vld = s9_vld_r;
    div_in_tag.inv = 1'b0;
    div_in_tag.tc  = s9_tc_r;
  end

  btpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (div_in_tag),
    .in_den   (s9_den_r),
    .in_n_neg (s9_nneg_r),
    .in_nabs  (s9_nabs_r),
    .out_tag  (div_tag),
    .out_p    (div_p)
  );

  // stage b: ph squared, split p times p8
  logic signed [23:0]    ph;
  logic signed [47:0]    phph_full;
  logic [44:0]           sb_phph_r;
  logic signed [34:0]    sb_p8l_nxt, sb_p8l_r, sb_p8h_nxt, sb_p8h_r;
  logic signed [P_W-1:0] sb_p_r;
  btpc_tag_t             sb_tag_r;

  always_comb begin
    ph         = 24'(div_p >>> 13);
    phph_full  = 48'(ph) * 48'(ph);
    sb_p8l_nxt = 35'($signed({1'b0, div_p[17:0]})) * 35'(p8);
    sb_p8h_nxt = 35'($signed(div_p[36:18])) * 35'(p8);
  end

  // stage c: split ph squared times p9, q2
  logic signed [39:0]    sc_q1h_nxt, sc_q1h_r, sc_q1l_nxt, sc_q1l_r;
  logic signed [63:0]    q2_full;
  logic signed [39:0]    sc_q2_r;
  logic signed [P_W-1:0] sc_p_r;
  btpc_tag_t             sc_tag_r;

  always_comb begin
    sc_q1h_nxt = 40'($signed({1'b0, sb_phph_r[44:22]})) * 40'(p9);
    sc_q1l_nxt = 40'($signed({1'b0, sb_phph_r[21:0]})) * 40'(p9);
    q2_full    = ((64'(sb_p8h_r) <<< 18) + 64'(sb_p8l_r)) >>> 19;
  end

  // stage d: q1
  logic signed [63:0]    q1_full;
  logic signed [39:0]    sd_q1_r, sd_q2_r;
  logic signed [P_W-1:0] sd_p_r;
  btpc_tag_t             sd_tag_r;

  assign q1_full = ((64'(sc_q1h_r) <<< 22) + 64'(sc_q1l_r)) >>> 25;

  // stage e: final sum, p7 offset, clamp
  logic signed [63:0]   psum, rr;
  logic [PRESS_W-1:0]   press_nxt;

  always_comb begin
    psum = 64'(sd_p_r) + 64'(sd_q1_r) + 64'(sd_q2_r);
    rr   = (psum >>> 8) + (64'(p7) <<< 4);
    if (sd_tag_r.inv || rr < 64'sd0) begin
      press_nxt = '0;
    end else if (rr > 64'(33'h0_ffff_ffff)) begin
      press_nxt = '1;
    end else begin
      press_nxt = rr[PRESS_W-1:0];
    end
  end

  logic                   out_vld_r;
  logic signed [TC_W-1:0] out_tc_r;
  logic [PRESS_W-1:0]     out_press_r;
  logic                   out_inv_r;

  // back pipeline valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_tag_r.vld <= 1'b0;
      sc_tag_r.vld <= 1'b0;
      sd_tag_r.vld <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      sb_tag_r  <= div_tag;
      sc_tag_r  <= sb_tag_r;
      sd_tag_r  <= sc_tag_r;
      out_vld_r <= sd_tag_r.vld;
    end
  end

  // back pipeline payload
  always_ff @(posedge clk) begin
    sb_phph_r   <= phph_full[44:0];
    sb_p8l_r    <= sb_p8l_nxt;
    sb_p8h_r    <= sb_p8h_nxt;
    sb_p_r      <= div_p;
    sc_q1h_r    <= sc_q1h_nxt;
    sc_q1l_r    <= sc_q1l_nxt;
    sc_q2_r     <= 40'(q2_full);
    sc_p_r      <= sb_p_r;
    sd_q1_r     <= 40'(q1_full);
    sd_q2_r     <= sc_q2_r;
    sd_p_r      <= sc_p_r;
    out_tc_r    <= sd_tag_r.tc;
    out_press_r <= press_nxt;
    out_inv_r   <= sd_tag_r.inv;
  end

  assign out_valid             = out_vld_r;
  assign out_temperature_centi = out_tc_r;
  assign out_pressure_q24_8    = out_press_r;
  assign out_pressure_invalid  = out_inv_r;

endmodule

// File: design/btpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_div
// Pipelined signed divide: p = trunc(3125 * n / den), saturated to +/-2^35.
// One quotient bit per restoring step stage, one beat accepted every cycle.
// ----------------------------------------------------------------------------
module btpc_div
  import btpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  btpc_tag_t                 in_tag,
  input  logic signed [DENS_W-1:0]  in_den,
  input  logic                      in_n_neg,
  input  logic [NABS_W-1:0]         in_nabs,
  output btpc_tag_t                 out_tag,
  output logic signed [P_W-1:0]     out_p
);

  // stage a: magnitudes, sign, zero divisor, numerator times 3125
  logic [DENS_W-1:0] dmag;
  logic [NUM_W-1:0]  nw;
  logic [DEN_W-1:0]  a_den_nxt, a_den_r;
  logic [NUM_W-1:0]  a_num_nxt, a_num_r;
  logic              a_sgn_nxt, a_sgn_r;
  btpc_tag_t         a_tag_nxt, a_tag_r;

  always_comb begin
    dmag      = in_den[DENS_W-1] ? DENS_W'(-in_den) : DENS_W'(in_den);
    a_den_nxt = dmag[DEN_W-1:0];
    nw        = NUM_W'(in_nabs);
    // 3125 = 2048 + 1024 + 32 + 16 + 4 + 1
    a_num_nxt = (nw << 11) + (nw << 10) + (nw << 5) + (nw << 4) + (nw << 2) + nw;
    a_sgn_nxt = in_n_neg ^ in_den[DENS_W-1];
    a_tag_nxt = in_tag;
    a_tag_nxt.inv = (in_den == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r.vld <= 1'b0;
    end else begin
      a_tag_r <= a_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_den_r <= a_den_nxt;
    a_num_r <= a_num_nxt;
    a_sgn_r <= a_sgn_nxt;
  end

  // step registers: index 0 holds the loaded partial remainder
  logic [DEN_W-1:0] dv_rem_r [0:DIV_W];
  logic [DIV_W-1:0] dv_num_r [0:DIV_W];
  logic [DEN_W-1:0] dv_den_r [0:DIV_W];
  logic             dv_sgn_r [0:DIV_W];
  logic             dv_ovf_r [0:DIV_W];
  btpc_tag_t        dv_tag_r [0:DIV_W];

  // load: overflow when the quotient would need more than DIV_W bits
  logic ovf_nxt;
  assign ovf_nxt = a_num_r >= NUM_W'({a_den_r, {DIV_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_tag_r[0].vld <= 1'b0;
    end else begin
      dv_tag_r[0] <= a_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    dv_rem_r[0] <= a_num_r[DIV_W +: DEN_W];
    dv_num_r[0] <= a_num_r[DIV_W-1:0];
    dv_den_r[0] <= a_den_r;
    dv_sgn_r[0] <= a_sgn_r;
    dv_ovf_r[0] <= ovf_nxt;
  end

  // restoring steps, quotient bits shift in where numerator bits leave
  for (genvar k = 0; k < DIV_W; k++) begin : g_step
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;
    logic [DIV_W-1:0] num_nxt;

    always_comb begin
      trial   = {dv_rem_r[k], dv_num_r[k][DIV_W-1]};
      ge      = trial >= {1'b0, dv_den_r[k]};
      rem_nxt = ge ? DEN_W'(trial - {1'b0, dv_den_r[k]}) : trial[DEN_W-1:0];
      num_nxt = {dv_num_r[k][DIV_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_tag_r[k+1].vld <= 1'b0;
      end else begin
        dv_tag_r[k+1] <= dv_tag_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_rem_r[k+1] <= rem_nxt;
      dv_num_r[k+1] <= num_nxt;
      dv_den_r[k+1] <= dv_den_r[k];
      dv_sgn_r[k+1] <= dv_sgn_r[k];
      dv_ovf_r[k+1] <= dv_ovf_r[k];
    end
  end

  // saturate magnitude and apply sign
  logic [DIV_W-1:0]      mag;
  logic signed [P_W-1:0] p_nxt, p_r;
  btpc_tag_t             tag_r;

  always_comb begin
    mag   = (dv_ovf_r[DIV_W] || (dv_num_r[DIV_W] > Q_SAT)) ? Q_SAT : dv_num_r[DIV_W];
    p_nxt = dv_sgn_r[DIV_W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else begin
      tag_r <= dv_tag_r[DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign out_tag = tag_r;
  assign out_p   = p_r;

endmodule
